// File: src/pce_gmr_pkg.sv
// Shared types and constants for the multiplexed gamepad reader.
// No dependencies; imported by pce_gamepad_mux_reader.
package pce_gmr_pkg;

   // Scan sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DPAD   = 3'd1,
      PH_BTN    = 3'd2,
      PH_CLR_HI = 3'd3,
      PH_CLR_LO = 3'd4,
      PH_SIG    = 3'd5,
      PH_EXT    = 3'd6
   } phase_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_POLL_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_SETTLE        = 2'd1;
   localparam logic [1:0] CSR_DEBOUNCE      = 2'd2;
   localparam logic [1:0] CSR_SIX_ENABLE    = 2'd3;

   // Reset values of the configuration registers
   localparam logic [23:0] POLL_INTERVAL_RST = 24'd16666;
   localparam logic [7:0]  SETTLE_RST        = 8'd6;
   localparam logic [23:0] DEBOUNCE_RST      = 24'd300000;
   localparam logic        SIX_ENABLE_RST    = 1'b1;

   // Nibble values
   localparam logic [3:0] NIBBLE_ONES = 4'hF;
   localparam logic [3:0] NIBBLE_ZERO = 4'h0;

   localparam int unsigned CFG_WIDTH = 24;

endpackage

// File: src/pce_gamepad_mux_reader.sv
// Multiplexed gamepad reader with optional six-button bank, one tick per transaction.
// Depends on pce_gmr_pkg (phase type, register indexes, reset constants).
//
// Each req transaction is one time tick carrying the sampled pad data lines; each tick
// yields exactly one rsp transaction with the SEL/CLR levels to drive from that tick on,
// the button report of a completed poll and the debounced connect state. The whole tick
// update is one pass of short logic from the sequencer and timer registers into the
// result register, so the block takes one transaction per clock cycle while rsp is not stalled.
// req_tready is high while the result register is empty or is being taken in the same
// cycle, so a new tick enters while the previous result is handed over; only a stalled
// rsp side holds the input back. A scan spans several ticks (settle waits after each
// SEL or CLR change), but that is time measured in ticks, not clock cycles.
// The configuration channel is always ready; writes are meant while no tick is in flight.
// Register indexes: 0 poll interval, 1 settle ticks, 2 debounce ticks, 3 six-button enable.
module pce_gamepad_mux_reader
   import pce_gmr_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = 24   // presence debounce counter width, 20..32
) (
   input  logic        clock,
   input  logic        reset,
   // tick input: [3:0] data_nibble, [7:4] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // result: [0] sel_level, [1] clr_level, [2] report_valid, [14:3] pressed,
   //         [15] connected, [16] six_pad, [17] disconnect_event, [23:18] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int unsigned CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
   localparam logic [TIMER_WIDTH-1:0] ELAPSED_MAX = {TIMER_WIDTH{1'b1}};
   localparam logic [TIMER_WIDTH-1:0] ELAPSED_ONE = TIMER_WIDTH'(1);

   // configuration
   logic [23:0] poll_interval_ff;
   logic [7:0]  settle_cfg_ff;
   logic [23:0] debounce_ff;
   logic        six_enable_ff;

   // sequencer and scan state
   phase_type                phase_ff, phase_in;
   logic [7:0]               settle_ff, settle_in;
   logic [23:0]              poll_timer_ff, poll_timer_in;
   logic [3:0]               dpad_ff, dpad_in;
   logic [3:0]               button_ff, button_in;
   logic [3:0]               sig_ff, sig_in;
   logic [3:0]               ext_ff, ext_in;
   logic                     six_flag_ff, six_flag_in;
   logic                     connected_ff, connected_in;
   logic                     presence_ff, presence_in;
   logic [TIMER_WIDTH-1:0]   elapsed_ff, elapsed_in;

   // result register
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic [3:0]  d;
   logic        done;
   logic [7:0]  settle_load;
   logic [23:0] poll_load;
   logic [7:0]  normal;
   logic        present;
   logic        stable;
   logic        report_valid;
   logic [11:0] pressed;
   logic        disc;
   logic        sel_level;
   logic        clr_level;
   logic [TIMER_WIDTH-1:0] elapsed_inc;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign d           = req_tdata[3:0];
   assign settle_load = (settle_cfg_ff == 8'd0) ? 8'd1 : settle_cfg_ff;
   assign poll_load   = (poll_interval_ff == 24'd0) ? 24'd1 : poll_interval_ff;
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + ELAPSED_ONE;

   // next state of the scan sequencer
   always_comb begin
      phase_in  = phase_ff;
      settle_in = settle_ff;
      done      = 1'b0;
      if (phase_ff != PH_IDLE) begin
         if (settle_ff > 8'd1) begin
            settle_in = settle_ff - 8'd1;
         end else begin
            settle_in = 8'd0;
            unique case (phase_ff)
               PH_DPAD: begin
                  phase_in  = PH_BTN;
                  settle_in = settle_load;
               end
               PH_BTN: begin
                  if (six_enable_ff) begin
                     phase_in  = PH_CLR_HI;
                     settle_in = settle_load;
                  end else begin
                     done = 1'b1;
                  end
               end
               PH_CLR_HI: begin
                  phase_in  = PH_CLR_LO;
                  settle_in = settle_load;
               end
               PH_CLR_LO: begin
                  phase_in  = PH_SIG;
                  settle_in = settle_load;
               end
               PH_SIG: begin
                  phase_in  = PH_EXT;
                  settle_in = settle_load;
               end
               PH_EXT: begin
                  done = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
      if (done) begin
         phase_in  = PH_IDLE;
         settle_in = 8'd0;
      end
      // next scan starts as soon as the reader is idle and the poll is due
      poll_timer_in = poll_timer_ff;
      if (phase_in == PH_IDLE && poll_timer_ff == 24'd0) begin
         phase_in      = PH_DPAD;
         settle_in     = settle_load;
         poll_timer_in = poll_load;
      end
      if (poll_timer_in != 24'd0) begin
         poll_timer_in = poll_timer_in - 24'd1;
      end
   end

   // data captured by the scan, presence debounce and report
   always_comb begin
      dpad_in      = dpad_ff;
      button_in    = button_ff;
      sig_in       = sig_ff;
      ext_in       = ext_ff;
      six_flag_in  = six_flag_ff;
      connected_in = connected_ff;
      presence_in  = presence_ff;
      elapsed_in   = elapsed_inc;
      disc         = 1'b0;
      report_valid = 1'b0;
      pressed      = 12'd0;

      if (phase_ff != PH_IDLE && settle_ff <= 8'd1) begin
         case (phase_ff)
            PH_DPAD: dpad_in = d;
            PH_BTN: begin
               button_in = d;
               if (!six_enable_ff) begin
                  six_flag_in = 1'b0;
                  ext_in      = NIBBLE_ONES;
               end
            end
            PH_SIG: sig_in = d;
            PH_EXT: begin
               if (sig_ff == NIBBLE_ZERO && dpad_ff != NIBBLE_ZERO) begin
                  six_flag_in = 1'b1;
                  ext_in      = d;
               end else begin
                  six_flag_in = 1'b0;
                  ext_in      = NIBBLE_ONES;
               end
            end
            default: ;
         endcase
      end

      normal  = {button_in, dpad_in};
      present = (normal != 8'd0);
      stable  = 1'b0;
      if (done) begin
         if (present != presence_ff) begin
            presence_in = present;
            elapsed_in  = '0;
         end
         stable = CMP_WIDTH'(elapsed_in) >= CMP_WIDTH'(debounce_ff);
         if (stable && present && !connected_ff) begin
            connected_in = 1'b1;
         end else if (stable && !present && connected_ff) begin
            connected_in = 1'b0;
            disc         = 1'b1;
         end
         if (connected_in) begin
            report_valid = 1'b1;
            pressed      = {(six_flag_in ? ~ext_in : 4'h0), ~normal};
         end
      end

      sel_level   = (phase_in == PH_DPAD) || (phase_in == PH_SIG);
      clr_level   = (phase_in == PH_CLR_HI);
      rsp_data_in = {6'd0, disc, six_flag_in, connected_in, pressed,
                     report_valid, clr_level, sel_level};
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_interval_ff <= POLL_INTERVAL_RST;
         settle_cfg_ff    <= SETTLE_RST;
         debounce_ff      <= DEBOUNCE_RST;
         six_enable_ff    <= SIX_ENABLE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_POLL_INTERVAL: poll_interval_ff <= csr_data;
            CSR_SETTLE:        settle_cfg_ff    <= csr_data[7:0];
            CSR_DEBOUNCE:      debounce_ff      <= csr_data;
            CSR_SIX_ENABLE:    six_enable_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // tick state, updated once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         settle_ff     <= 8'd0;
         poll_timer_ff <= 24'd0;
         dpad_ff       <= NIBBLE_ZERO;
         button_ff     <= NIBBLE_ZERO;
         sig_ff        <= NIBBLE_ZERO;
         ext_ff        <= NIBBLE_ONES;
         six_flag_ff   <= 1'b0;
         connected_ff  <= 1'b0;
         presence_ff   <= 1'b0;
         elapsed_ff    <= '0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         settle_ff     <= settle_in;
         poll_timer_ff <= poll_timer_in;
         dpad_ff       <= dpad_in;
         button_ff     <= button_in;
         sig_ff        <= sig_in;
         ext_ff        <= ext_in;
         six_flag_ff   <= six_flag_in;
         connected_ff  <= connected_in;
         presence_ff   <= presence_in;
         elapsed_ff    <= elapsed_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a report is only issued while connected
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[2] |-> rsp_data_ff[15])
      else $error("report without connected pad");

   // a disconnect transaction always shows the pad disconnected, with no report
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[17] |-> !rsp_data_ff[15] && !rsp_data_ff[2])
      else $error("disconnect event with pad still connected");

   // pressed bits are zero outside a report
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[2] |-> rsp_data_ff[14:3] == 12'd0)
      else $error("pressed bits set without report");

   // an idle reader with the poll due starts a scan on the next tick
   assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_IDLE && poll_timer_ff == 24'd0 |=> phase_ff == PH_DPAD)
      else $error("due poll did not start a scan");

   // the settle timer is clear whenever the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> settle_ff == 8'd0)
      else $error("settle timer running while idle");

endmodule
